[design/speck96_pkg.sv]
// shared types, constants and round functions for the speck96 cipher core
// no dependencies; imported by every module of the block
package speck96_pkg;

  localparam int WORD_W         = 48;
  localparam int RC_W           = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int KEY_WORDS_DEF  = 2;
  localparam int MAX_ROUNDS_DEF = 28;
  localparam int ROT_A          = 8;
  localparam int ROT_B          = 3;

  localparam logic [RC_W-1:0] RC_RESET = RC_W'(28);

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } block_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD_0,
    CFG_KEY_WORD_1,
    CFG_KEY_WORD_2,
    CFG_ROUND_COUNT
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_FWD,
    RING_BWD
  } ring_op_t;

  typedef enum logic [1:0] {
    DP_HOLD,
    DP_LOAD,
    DP_FWD,
    DP_INV
  } dp_op_t;

  function automatic word_t rotr(word_t v, int s);
    return (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // x' = ((x >>> 8) + y) ^ k, y' = (y <<< 3) ^ x'
  function automatic block_t fwd_round(block_t b, word_t k);
    block_t r;
    word_t  a;
    a   = (rotr(b.x, ROT_A) + b.y) ^ k;
    r.x = a;
    r.y = rotl(b.y, ROT_B) ^ a;
    return r;
  endfunction

  function automatic block_t inv_round(block_t b, word_t k);
    block_t r;
    word_t  yb;
    word_t  a;
    yb  = rotr(b.y ^ b.x, ROT_B);
    a   = (b.x ^ k) - yb;
    r.x = rotl(a, ROT_A);
    r.y = yb;
    return r;
  endfunction

endpackage

[design/speck96_key_cell.sv]
// one cell of the round key ring: holds one round key word
// depends on speck96_pkg; shifts toward either neighbor or holds
module speck96_key_cell import speck96_pkg::*; (
  input  logic     clk,
  input  ring_op_t op,
  input  word_t    from_next,
  input  word_t    from_prev,
  output word_t    key
);

  always_ff @(posedge clk) begin
    case (op)
      RING_FWD: key <= from_next;
      RING_BWD: key <= from_prev;
      default:  key <= key;
    endcase
  end

endmodule

[design/speck96_round_unit.sv]
// block register with one shared forward/inverse round per cycle unless op holds or loads
// depends on speck96_pkg round functions
module speck96_round_unit import speck96_pkg::*; (
  input  logic   clk,
  input  dp_op_t op,
  input  block_t load_blk,
  input  word_t  key,
  output block_t blk,
  output block_t blk_next
);

  always_comb begin
    case (op)
      DP_LOAD: blk_next = load_blk;
      DP_FWD:  blk_next = fwd_round(blk, key);
      DP_INV:  blk_next = inv_round(blk, key);
      default: blk_next = blk;
    endcase
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
  end

endmodule

[design/speck96_block_cipher_core.sv]
// speck 96 block cipher core: key schedule, round key ring, round unit
// depends on speck96_pkg, speck96_key_cell, speck96_round_unit
//
// usage
//   input channel: in_valid / in_stall carry one beat of command, left_in,
//   right_in; command 0 encrypts, 1 decrypts. output channel: out_valid /
//   out_stall carry one beat of left_out, right_out per input beat.
//   config port: cfg_write, cfg_index, cfg_data write the key words and the
//   round count; write only while no block is in flight.
//   key schedule: any config write drops the keys; the ring of MAX_ROUNDS
//   key cells is refilled, and in_stall stays high until it is done.
//   after reset the same fill runs. the block takes a new beat only once
//   the previous one has left the round unit, since the key ring makes one
//   full turn per block through the single round unit.
//   a finished block waits in the output register while the next one is
//   accepted and worked on; if the receiver still stalls when that one is
//   done, it holds in the round unit until the output register frees up.
//   reset (rst, synchronous) clears keys, sets round count to 28 and
//   empties the output register.
module speck96_block_cipher_core import speck96_pkg::*; #(
  parameter int KEY_WORDS  = KEY_WORDS_DEF,
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [WORD_W-1:0]    left_in,
  input  logic [WORD_W-1:0]    right_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    left_out,
  output logic [WORD_W-1:0]    right_out
);

  localparam int STEP_W = $clog2(MAX_ROUNDS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_ROUNDS - 1);
  localparam logic [RC_W-1:0]   MAX_RC    = RC_W'(MAX_ROUNDS);

  // configuration registers
  word_t             key_word_0;
  word_t             key_word_1;
  word_t             key_word_2;
  logic [RC_W-1:0]   round_count;
  logic              keys_ready;

  // control
  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              dir;
  logic              last;
  logic              in_accept;
  logic              out_free;
  logic              out_load;

  // key schedule chain
  word_t             kcur;
  word_t             chain_a;
  word_t             chain_b;
  block_t            sched_in;
  block_t            sched;

  // key ring and datapath
  word_t             ring_key [MAX_ROUNDS];
  word_t             tail_in;
  ring_op_t          ring_op;
  dp_op_t            dp_op;
  word_t             round_key;
  block_t            in_blk;
  block_t            blk;
  block_t            blk_next;
  block_t            out_blk;

  // round window
  logic [RC_W-1:0]   n_rounds;
  logic [RC_W-1:0]   dec_start;
  logic [RC_W-1:0]   step_ext;
  logic              round_active;

  // ---------------------------------------------------------------
  // configuration writes; any write drops the key store
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0  <= '0;
      key_word_1  <= '0;
      key_word_2  <= '0;
      round_count <= RC_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_KEY_WORD_0:  key_word_0  <= cfg_data;
        CFG_KEY_WORD_1:  key_word_1  <= cfg_data;
        CFG_KEY_WORD_2:  key_word_2  <= cfg_data;
        CFG_ROUND_COUNT: round_count <= cfg_data[RC_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
    end else if (cfg_write) begin
      keys_ready <= 1'b0;
    end else if (state == ST_BUILD && last) begin
      keys_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // handshake terms
  // ---------------------------------------------------------------
  assign in_stall  = !(state == ST_IDLE && keys_ready);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last      = (step == LAST_STEP);

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cfg_write && !keys_ready) begin
          state_next = ST_BUILD;
        end else if (in_accept) begin
          state_next = ST_RUN;
        end
      end
      ST_BUILD: begin
        // a write mid-fill restarts the schedule from the new key
        if (cfg_write || last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_next = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if ((state == ST_BUILD || state == ST_RUN) && state_next == state) begin
      step_next = step + STEP_W'(1);
    end else begin
      step_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // ---------------------------------------------------------------
  // round window: encrypt uses steps below n, decrypt the last n steps
  // ---------------------------------------------------------------
  assign n_rounds     = (round_count > MAX_RC) ? MAX_RC : round_count;
  assign dec_start    = MAX_RC - n_rounds;
  assign step_ext     = RC_W'(step);
  assign round_active = dir ? (step_ext >= dec_start) : (step_ext < n_rounds);

  // ---------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------
  always_comb begin
    ring_op  = RING_HOLD;
    dp_op    = DP_HOLD;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          dp_op = DP_LOAD;
        end
      end
      ST_BUILD: begin
        ring_op = RING_FWD;
      end
      ST_RUN: begin
        // one full turn of the ring per block leaves it aligned again
        ring_op = dir ? RING_BWD : RING_FWD;
        if (round_active) begin
          dp_op = dir ? DP_INV : DP_FWD;
        end
        out_load = last && out_free;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // key schedule: round function on the chain with the step as key
  // ---------------------------------------------------------------
  always_comb begin
    sched_in.x = chain_a;
    sched_in.y = kcur;
    sched      = fwd_round(sched_in, word_t'(step));
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      kcur    <= key_word_0;
      chain_a <= key_word_1;
      chain_b <= key_word_2;
    end else if (state == ST_BUILD) begin
      kcur    <= sched.y;
      chain_a <= (KEY_WORDS == 3) ? chain_b : sched.x;
      chain_b <= sched.x;
    end
  end

  // ---------------------------------------------------------------
  // round key ring: keys enter at the tail during the fill, then rotate
  // ---------------------------------------------------------------
  assign tail_in = (state == ST_BUILD) ? kcur : ring_key[0];

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_ring
    word_t nb_next;
    word_t nb_prev;
    if (i == MAX_ROUNDS - 1) begin : g_tail
      assign nb_next = tail_in;
    end else begin : g_mid
      assign nb_next = ring_key[i+1];
    end
    if (i == 0) begin : g_head
      assign nb_prev = ring_key[MAX_ROUNDS-1];
    end else begin : g_body
      assign nb_prev = ring_key[i-1];
    end
    speck96_key_cell u_cell (
      .clk       (clk),
      .op        (ring_op),
      .from_next (nb_next),
      .from_prev (nb_prev),
      .key       (ring_key[i])
    );
  end

  // encrypt reads the head, decrypt reads the tail while turning backward
  assign round_key = dir ? ring_key[MAX_ROUNDS-1] : ring_key[0];

  // ---------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dir <= command;
    end
  end

  assign in_blk.x = left_in;
  assign in_blk.y = right_in;

  speck96_round_unit u_round (
    .clk      (clk),
    .op       (dp_op),
    .load_blk (in_blk),
    .key      (round_key),
    .blk      (blk),
    .blk_next (blk_next)
  );

  // last step hands its own result straight to the output register
  assign out_blk = (state == ST_RUN) ? blk_next : blk;

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= out_blk.x;
      right_out <= out_blk.y;
    end
  end

endmodule

[design/speck96_checker.sv]
// port-level checks for the speck96 cipher core, bound to the top level
// depends on speck96_pkg and speck96_block_cipher_core
module speck96_checker import speck96_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cfg_write,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] left_out,
  input logic [WORD_W-1:0] right_out
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled output beat changed");

  // one block at a time: accepting a beat closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // a config write forces a key refill before the next beat
  a_cfg_refill: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("input open right after config write");

  // no result can appear the cycle after a beat is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared without running the rounds");

endmodule

bind speck96_block_cipher_core speck96_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_write (cfg_write),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .left_out  (left_out),
  .right_out (right_out)
);
